// ----- rtl/core/sha256_byte_stream_hasher_unit_defines.svh -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit_defines
// Assertion macros for the SHA-256 byte-stream hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
// Check that a property holds on every rising clock edge outside reset.
`define SHB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property that must also hold during reset.
`define SHB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/core/shb_pkg.sv -----
// ----------------------------------------------------------------------------
// shb_pkg
// Types, constants and round functions of the SHA-256 byte-stream hasher.
// ----------------------------------------------------------------------------
package shb_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 64;
   localparam int unsigned HashWords  = 8;
   localparam logic [7:0]  PadMark    = 8'h80;
   localparam logic [5:0]  LenPos     = 6'd56;
   localparam logic        ActData    = 1'b0;
   localparam logic        ActFinish  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCHED,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitH [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ----- rtl/core/shb_if.sv -----
// ----------------------------------------------------------------------------
// shb_req_if / shb_rsp_if
// Valid/ready channels for message beats and digest beats.
// ----------------------------------------------------------------------------
interface shb_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface shb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/core/sha256_byte_stream_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream with padding, length and digest output.
// ----------------------------------------------------------------------------
// channel   dir  beat
// req       in   action, data_byte   (one message byte or a finish)
// rsp       out  digest_word, word_index, last_word (eight beats per finish)
//
// A data byte is absorbed when taken; the 64th byte of a block then runs the schedule,
// round and fold states, all through one shared round datapath.
// Finish feeds 9 to 72 padding bytes through the data byte path at one a cycle
// outside compressions, plus one or two compressions, then 8 digest beats, each held until taken.
// Reset restores the initial hash and clears counters; req is held off while
// a block compresses, padding runs or digest beats are pending.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit (
   input logic clock,
   input logic reset,
   shb_req_if.sink   req,
   shb_rsp_if.source rsp
);

   shb_pkg::state_type state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] w_ff [16];
   logic [31:0] av_ff [8];
   logic [31:0] partial_ff;
   logic [5:0]  bytes_ff;
   logic [63:0] bits_ff;
   logic [63:0] len_ff;
   logic [5:0]  cnt_ff;
   logic [3:0]  padn_ff;
   logic        padding_ff;
   logic        extra_ff;
   logic [2:0]  idx_ff;

   logic        absorb;
   logic [7:0]  abyte;
   logic        len_phase;
   logic        last_beat;
   logic [31:0] new_w, t1, t2;
   logic [5:0]  bsum;

   assign len_phase = padding_ff && !extra_ff && (bytes_ff >= shb_pkg::LenPos);
   assign last_beat = (state_ff == shb_pkg::ST_EMIT) && rsp.ready && (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      absorb   = 1'b0;
      abyte    = 8'h00;
      case (state_ff)
         shb_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (req.action == shb_pkg::ActData) begin
                  absorb = 1'b1;
                  abyte  = req.data_byte;
                  if (bytes_ff == 6'd63) state_in = shb_pkg::ST_SCHED;
               end else begin
                  state_in = shb_pkg::ST_PAD;
               end
            end
         end
         shb_pkg::ST_PAD: begin
            absorb = 1'b1;
            if (!padding_ff) abyte = shb_pkg::PadMark;
            else if (len_phase) abyte = len_ff[63:56];
            if (bytes_ff == 6'd63) state_in = shb_pkg::ST_SCHED;
         end
         shb_pkg::ST_SCHED: if (cnt_ff == 6'd47) state_in = shb_pkg::ST_ROUND;
         shb_pkg::ST_ROUND: if (cnt_ff == 6'd63) state_in = shb_pkg::ST_FOLD;
         shb_pkg::ST_FOLD:
            state_in = (padn_ff == 4'd8) ? shb_pkg::ST_EMIT :
                       (padding_ff ? shb_pkg::ST_PAD : shb_pkg::ST_IDLE);
         shb_pkg::ST_EMIT:
            if (rsp.ready && idx_ff == 3'd7) state_in = shb_pkg::ST_IDLE;
         default: state_in = shb_pkg::ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == shb_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == shb_pkg::ST_EMIT);
   assign rsp.digest_word = hash_ff[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);

   // Schedule: W[t] from a 16-deep shift line; rounds read and rotate it.
   assign new_w = shb_pkg::small_s1(w_ff[14]) + w_ff[9]
                + shb_pkg::small_s0(w_ff[1]) + w_ff[0];
   assign t1 = av_ff[7] + shb_pkg::big_s1(av_ff[4])
             + ((av_ff[4] & av_ff[5]) ^ (~av_ff[4] & av_ff[6]))
             + shb_pkg::RoundK[cnt_ff] + w_ff[0];
   assign t2 = shb_pkg::big_s0(av_ff[0])
             + ((av_ff[0] & av_ff[1]) ^ (av_ff[0] & av_ff[2]) ^ (av_ff[1] & av_ff[2]));
   assign bsum = bytes_ff + 6'd1;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= shb_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset || last_beat) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= shb_pkg::InitH[i];
         partial_ff <= 32'h0;
         bytes_ff   <= 6'd0;
         bits_ff    <= 64'd0;
         padn_ff    <= 4'd0;
         padding_ff <= 1'b0;
         extra_ff   <= 1'b0;
         idx_ff     <= 3'd0;
         cnt_ff     <= 6'd0;
      end else begin
         if (absorb) begin
            bytes_ff <= bsum;
            if (bsum[1:0] == 2'b00) begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15]   <= {partial_ff[23:0], abyte};
               partial_ff <= 32'h0;
            end else begin
               partial_ff <= {partial_ff[23:0], abyte};
            end
         end
         if (state_in == shb_pkg::ST_SCHED && state_ff != shb_pkg::ST_SCHED) begin
            cnt_ff <= 6'd0;
            for (int i = 0; i < 8; i++) av_ff[i] <= hash_ff[i];
         end
         case (state_ff)
            shb_pkg::ST_IDLE: begin
               if (req.valid) begin
                  if (req.action == shb_pkg::ActData) bits_ff <= bits_ff + 64'd8;
                  else len_ff <= bits_ff;
               end
            end
            shb_pkg::ST_PAD: begin
               padding_ff <= 1'b1;
               if (!padding_ff)
                  extra_ff <= (bytes_ff >= shb_pkg::LenPos) && (bytes_ff != 6'd63);
               else if (bytes_ff == 6'd63)
                  extra_ff <= 1'b0;
               if (len_phase) begin
                  padn_ff <= padn_ff + 4'd1;
                  len_ff  <= {len_ff[55:0], 8'h00};
               end
            end
            shb_pkg::ST_SCHED: begin
               // Hold the window; rounds extend it on the fly.
               cnt_ff <= (cnt_ff == 6'd47) ? 6'd0 : cnt_ff + 6'd1;
            end
            shb_pkg::ST_ROUND: begin
               cnt_ff <= cnt_ff + 6'd1;
               av_ff[7] <= av_ff[6]; av_ff[6] <= av_ff[5]; av_ff[5] <= av_ff[4];
               av_ff[4] <= av_ff[3] + t1;
               av_ff[3] <= av_ff[2]; av_ff[2] <= av_ff[1]; av_ff[1] <= av_ff[0];
               av_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= new_w;
            end
            shb_pkg::ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + av_ff[i];
            end
            shb_pkg::ST_EMIT: begin
               if (rsp.ready) idx_ff <= idx_ff + 3'd1;
            end
            default: ;
         endcase
      end
   end

   `SHB_ASSERT(a_no_req_busy, clock, reset, (state_ff != shb_pkg::ST_IDLE) |-> !req.ready, "req ready while busy")
   `SHB_ASSERT(a_emit_word_zero, clock, reset, $rose(rsp.valid) |-> (rsp.word_index == 3'd0), "digest did not start at word 0")
   `SHB_ASSERT(a_last_to_idle, clock, reset, (rsp.valid && rsp.ready && rsp.last_word) |=> req.ready, "not idle after last digest beat")

endmodule
